@@ sv/indexed_array_table_defines.svh @@
// Assertion macros shared by the indexed array table RTL.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef INDEXED_ARRAY_TABLE_DEFINES_SVH
`define INDEXED_ARRAY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/iat_pkg.sv @@
// Package for the indexed array table: widths, command and status codes,
// and the control struct broadcast from the decoder to the cells. No dependencies.
`default_nettype none

package iat_pkg;

    localparam int DEF_CAPACITY = 8;
    localparam int CAP_MAX      = 64;
    // position / count width that covers every capacity in range
    localparam int PW           = $clog2(CAP_MAX + 1);

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 3;
    localparam int COUNT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_ORD = 3'd0,
        CMD_INS_UN  = 3'd1,
        CMD_REM_ORD = 3'd2,
        CMD_REM_UN  = 3'd3,
        CMD_FIND    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Per-request control seen by every cell; operation flags are
    // already qualified by an accepted request with ok status.
    typedef struct packed {
        logic          ins_ord;
        logic          ins_un;
        logic          rem_ord;
        logic          rem_un;
        logic          find;
        logic [PW-1:0] idx;
        logic [PW-1:0] cnt;
        logic [PW-1:0] sel;
    } iat_ctrl_t;

endpackage

`default_nettype wire

@@ sv/indexed_array_table.sv @@
// Top level of the indexed array table: decoder, row of entry cells, fill
// count and result registers. Uses iat_pkg, iat_dec, iat_cell and the defines header.
//
// Usage:
//   Request channel: drive command, index and value with start high; a request
//   is taken at a rising edge with start high and busy low. busy stays low, so
//   a new request can be taken on every clock.
//   Result channel: done is high for exactly one cycle, the cycle after the
//   request was taken, with status, found, found_index and count. Throughput is
//   one request per cycle; every insert, remove and find completes in the cells
//   in the cycle the request is taken (the find priority chain across the row
//   is the longest path).
//   The receiver cannot stall; results must be taken when done is high.
//   Reset (rst_n low) empties the table (count zero) and clears done. Entries
//   are not cleared; an entry only becomes visible after it was written.
//   Commands other than the five defined ones give status ok and no change.
`default_nettype none

`include "indexed_array_table_defines.svh"

module indexed_array_table
    import iat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [CMD_W-1:0]       command,
    input  wire logic [IDX_W-1:0]       index,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                        done,
    output logic      [STATUS_W-1:0]    status,
    output logic                        found,
    output logic      [FIDX_W-1:0]      found_index,
    output logic      [COUNT_W-1:0]     count
);

    localparam int CW = $clog2(CAPACITY + 1);

    iat_ctrl_t         ctrl;
    status_t           st;
    logic [PW-1:0]     cnt_next;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] q_arr     [CAPACITY];
    logic [DATA_W-1:0] left_arr  [CAPACITY];
    logic [DATA_W-1:0] right_arr [CAPACITY];
    logic [CAPACITY:0] hit;
    logic [CAPACITY-1:0] first;
    logic [DATA_W-1:0] bus;
    logic [PW-1:0]     fenc;
    logic              accept;

    logic              done_reg;
    status_t           status_reg;
    logic              found_reg;
    logic [FIDX_W-1:0] found_index_reg;
    logic [COUNT_W-1:0] count_reg;

    // Every request finishes in the cycle it is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    iat_dec #(
        .CAPACITY (CAPACITY)
    ) u_dec (
        .start    (accept),
        .command  (command),
        .index    (index),
        .cnt      (PW'(cnt_reg)),
        .ctrl     (ctrl),
        .status   (st),
        .cnt_next (cnt_next)
    );

    // Row of cells with neighbor links
    assign hit[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_arr[i] = '0;
        end
        else
        begin : g_mid_l
            assign left_arr[i] = q_arr[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_arr[i] = '0;
        end
        else
        begin : g_mid_r
            assign right_arr[i] = q_arr[i+1];
        end

        iat_cell #(
            .POS (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .value   (value),
            .left_q  (left_arr[i]),
            .right_q (right_arr[i]),
            .bus     (bus),
            .hit_in  (hit[i]),
            .q       (q_arr[i]),
            .hit_out (hit[i+1]),
            .first   (first[i])
        );
    end

    // Shared bus: entry at the index (unordered insert) or last entry
    // (unordered remove)
    always_comb
    begin
        bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (PW'(i) == ctrl.sel)
                bus = bus | q_arr[i];
        end
    end

    // Encode the one-hot first match
    always_comb
    begin
        fenc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first[i])
                fenc = fenc | PW'(i);
        end
    end

    // Fill count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next[CW-1:0];
            done_reg <= accept;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= st;
            found_reg       <= ctrl.find && hit[CAPACITY];
            found_index_reg <= (ctrl.find && hit[CAPACITY]) ? fenc[FIDX_W-1:0] : '0;
            count_reg       <= cnt_next[COUNT_W-1:0];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign count       = count_reg;

    // Checks
    `IAT_ASSERT_IMP(a_cnt_bound, 1'b1, PW'(cnt_reg) <= PW'(CAPACITY), "fill count over capacity")
    `IAT_ASSERT_NXT(a_done_after_req, accept, done_reg, "no result after request")
    `IAT_ASSERT_NXT(a_no_spurious_done, !accept, !done_reg, "result without request")
    `IAT_ASSERT_IMP(a_found_ok, done_reg && found_reg, status_reg == ST_OK, "found with error status")
    `IAT_ASSERT_NXT(a_err_keeps_cnt, accept && (st != ST_OK), cnt_reg == $past(cnt_reg), "error changed count")

endmodule

`default_nettype wire

@@ sv/iat_dec.sv @@
// Request decoder for the indexed array table: range and full checks,
// next fill count, and the control broadcast to the cells. Uses iat_pkg.
`default_nettype none

module iat_dec
    import iat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                start,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [IDX_W-1:0]    index,
    input  wire logic [PW-1:0]       cnt,
    output iat_ctrl_t                ctrl,
    output status_t                  status,
    output logic      [PW-1:0]       cnt_next
);

    logic          is_ins;
    logic          is_rem;
    logic          ok;
    logic [PW-1:0] idx_e;

    assign idx_e  = PW'(index);
    assign is_ins = (command == CMD_INS_ORD) || (command == CMD_INS_UN);
    assign is_rem = (command == CMD_REM_ORD) || (command == CMD_REM_UN);

    // Index checked before fullness on inserts
    always_comb
    begin
        status = ST_OK;
        if (is_ins)
        begin
            if (idx_e > cnt)
                status = ST_BAD_INDEX;
            else if (cnt >= PW'(CAPACITY))
                status = ST_FULL;
        end
        else if (is_rem)
        begin
            if (idx_e >= cnt)
                status = ST_BAD_INDEX;
        end
    end

    assign ok = start && (status == ST_OK);

    // Fill count update
    always_comb
    begin
        cnt_next = cnt;
        if (ok && is_ins)
            cnt_next = cnt + PW'(1);
        else if (ok && is_rem)
            cnt_next = cnt - PW'(1);
    end

    // Broadcast control; sel picks the cell that feeds the shared bus
    always_comb
    begin
        ctrl.ins_ord = ok && (command == CMD_INS_ORD);
        ctrl.ins_un  = ok && (command == CMD_INS_UN);
        ctrl.rem_ord = ok && (command == CMD_REM_ORD);
        ctrl.rem_un  = ok && (command == CMD_REM_UN);
        ctrl.find    = ok && (command == CMD_FIND);
        ctrl.idx     = idx_e;
        ctrl.cnt     = cnt;
        ctrl.sel     = (command == CMD_INS_UN) ? idx_e : (cnt - PW'(1));
    end

endmodule

`default_nettype wire

@@ sv/iat_cell.sv @@
// One table cell: holds one entry, shifts with its neighbors and matches
// against the search value. Uses iat_pkg.
`default_nettype none

module iat_cell
    import iat_pkg::*;
#(
    parameter int POS = 0
) (
    input  wire logic                 clk,
    input  wire iat_ctrl_t            ctrl,
    input  wire logic [DATA_W-1:0]    value,
    input  wire logic [DATA_W-1:0]    left_q,
    input  wire logic [DATA_W-1:0]    right_q,
    input  wire logic [DATA_W-1:0]    bus,
    input  wire logic                 hit_in,
    output logic      [DATA_W-1:0]    q,
    output logic                      hit_out,
    output logic                      first
);

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic              we;
    logic [DATA_W-1:0] data_next;
    logic              match;
    logic [DATA_W-1:0] data_reg;

    // Select the new entry for this position
    always_comb
    begin
        we        = 1'b0;
        data_next = value;
        if (ctrl.ins_ord)
        begin
            if (MY_POS == ctrl.idx)
                we = 1'b1;
            else if ((MY_POS > ctrl.idx) && (MY_POS <= ctrl.cnt))
            begin
                we        = 1'b1;
                data_next = left_q;
            end
        end
        else if (ctrl.ins_un)
        begin
            if (MY_POS == ctrl.idx)
                we = 1'b1;
            else if (MY_POS == ctrl.cnt)
            begin
                we        = 1'b1;
                data_next = bus;
            end
        end
        else if (ctrl.rem_ord)
        begin
            if ((MY_POS >= ctrl.idx) && ((MY_POS + PW'(1)) < ctrl.cnt))
            begin
                we        = 1'b1;
                data_next = right_q;
            end
        end
        else if (ctrl.rem_un)
        begin
            if (MY_POS == ctrl.idx)
            begin
                we        = 1'b1;
                data_next = bus;
            end
        end
    end

    // Entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        if (we)
            data_reg <= data_next;
    end

    assign q = data_reg;

    // Search chain: first filled cell that matches wins
    assign match   = (data_reg == value) && (MY_POS < ctrl.cnt);
    assign hit_out = hit_in || match;
    assign first   = match && !hit_in;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for indexed_array_table: a directed request table, then
// random requests, each result compared with the row's expected result or a shadow copy.
// Depends on iat_pkg and the indexed_array_table RTL.
`timescale 1ns / 100ps

module tb_top;
    import iat_pkg::*;

    localparam int DEPTH        = DEF_CAPACITY;
    localparam int N_RANDOM     = 450;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_LIMIT  = 100;

    // command codes the block decodes as no operation
    localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FIDX_W-1:0]   found_index;
        logic [COUNT_W-1:0]  count;
    } table_resp_t;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        table_resp_t              resp;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [CMD_W-1:0]           command = '0;
    logic [IDX_W-1:0]           index = '0;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic [FIDX_W-1:0]          found_index;
    logic [COUNT_W-1:0]         count;

    // shadow copy of the table contents and fill count
    logic signed [DATA_W-1:0]   shadow_tbl [DEPTH];
    int                         shadow_cnt;

    table_resp_t                pending_resp_q [$];
    stim_row_t                  dir_rows [$];
    int                         n_errs;
    bit                         req_taken;
    bit                         row_typed;
    table_resp_t                row_resp;

    indexed_array_table i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .index       (index),
        .value       (value),
        .done        (done),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #200_000;
        $display("Regression FAIL");
        $finish;
    end

    // Apply one request to the shadow table and return the result it should give
    function automatic table_resp_t table_op_result(logic [CMD_W-1:0] cmd,
                                                    logic [IDX_W-1:0] idx,
                                                    logic signed [DATA_W-1:0] val);
        table_resp_t r;
        int          i;
        r = '0;
        r.status = ST_OK;
        unique case (cmd)
            CMD_INS_ORD, CMD_INS_UN:
            begin
                if (idx > shadow_cnt)
                    r.status = ST_BAD_INDEX;
                else if (shadow_cnt >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (cmd == CMD_INS_ORD)
                    begin
                        for (i = shadow_cnt; i > idx; i--)
                            shadow_tbl[i] = shadow_tbl[i-1];
                    end
                    else
                        shadow_tbl[shadow_cnt] = shadow_tbl[idx];
                    shadow_tbl[idx] = val;
                    shadow_cnt++;
                end
            end
            CMD_REM_ORD, CMD_REM_UN:
            begin
                if (idx >= shadow_cnt)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    shadow_cnt--;
                    if (cmd == CMD_REM_ORD)
                    begin
                        for (i = idx; i < shadow_cnt; i++)
                            shadow_tbl[i] = shadow_tbl[i+1];
                    end
                    else
                        shadow_tbl[idx] = shadow_tbl[shadow_cnt];
                end
            end
            CMD_FIND:
            begin
                // lowest matching position wins
                for (i = 0; i < shadow_cnt && !r.found; i++)
                begin
                    if (shadow_tbl[i] == val)
                    begin
                        r.found = 1'b1;
                        r.found_index = i[FIDX_W-1:0];
                    end
                end
            end
            default:
            begin
                // unused codes leave the table alone
            end
        endcase
        r.count = shadow_cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i,
                                         logic [DATA_W-1:0] v, bit t,
                                         logic [STATUS_W-1:0] s, logic f,
                                         logic [FIDX_W-1:0] fi, logic [COUNT_W-1:0] n);
        stim_row_t row;
        row.cmd = c;
        row.idx = i;
        row.val = v;
        row.typed = t;
        row.resp.status = s;
        row.resp.found = f;
        row.resp.found_index = fi;
        row.resp.count = n;
        return row;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        unique case ($urandom_range(3))
            0:       return $urandom_range(0, 6) - 3;
            1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Wait for a clock edge, check a returned result, then record an accepted request
    task automatic tick();
        table_resp_t want;
        table_resp_t got;
        @(posedge clk);
        req_taken = 1'b0;
        if (done === 1'b1)
        begin
            got = {status, found, found_index, count};
            if (pending_resp_q.size() == 0)
            begin
                n_errs++;
                if (n_errs <= MAX_REPORTS)
                    $display("ERROR: unexpected result at %0t: %s%0d found=%0d idx=%0d count=%0d",
                             $realtime, "status=", got.status, got.found,
                             got.found_index, got.count);
            end
            else
            begin
                want = pending_resp_q.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.found_index !== want.found_index || got.count !== want.count)
                begin
                    n_errs++;
                    if (n_errs <= MAX_REPORTS)
                        $display({"ERROR: mismatch at %0t: status %0d/%0d found %0d/%0d ",
                                  "idx %0d/%0d count %0d/%0d (exp/act)"},
                                 $realtime, want.status, got.status, want.found, got.found,
                                 want.found_index, got.found_index, want.count, got.count);
                end
            end
        end
        if (start === 1'b1 && busy === 1'b0)
        begin
            want = table_op_result(command, index, value);
            if (row_typed)
                want = row_resp;
            pending_resp_q.push_back(want);
            req_taken = 1'b1;
        end
    endtask

    // Present one request, with an optional random gap first
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] val, bit typed,
                            table_resp_t exp_resp, bit may_idle);
        int gap;
        gap = (may_idle && $urandom_range(99) < 38) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) tick();
        end
        start <= 1'b1;
        command <= cmd;
        index <= idx;
        value <= val;
        row_typed = typed;
        row_resp = exp_resp;
        do
            tick();
        while (!req_taken);
    endtask

    // Hold off requests until every outstanding result is back or the wait limit is hit
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            tick();
            waited++;
        end
        while (pending_resp_q.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    initial
    begin
        stim_row_t          row;
        int                 k;
        int                 ins_pct;
        bit                 no_idle;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic signed [DATA_W-1:0] val;

        n_errs = 0;
        shadow_cnt = 0;
        row_typed = 1'b0;
        row_resp = '0;
        req_taken = 1'b0;
        foreach (shadow_tbl[j])
            shadow_tbl[j] = '0;

        // Directed requests: empty table, append, full table, duplicates, unused codes
        dir_rows.push_back(mk_row(CMD_FIND,    4'd0, 32'h0,         1, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_REM_ORD, 4'd0, 32'h0,         1, ST_BAD_INDEX, 0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_REM_UN,  4'd0, 32'h0,         1, ST_BAD_INDEX, 0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd1, 32'h1,         1, ST_BAD_INDEX, 0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd0, 32'h7fff_ffff, 1, ST_OK,        0, 0, 4'd1));
        dir_rows.push_back(mk_row(CMD_INS_UN,  4'd1, 32'h8000_0000, 1, ST_OK,        0, 0, 4'd2));
        dir_rows.push_back(mk_row(CMD_INS_UN,  4'd0, 32'hffff_ffff, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd3, 32'h0,         0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_FIND,    4'd0, 32'h8000_0000, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_NOP_FIRST, 4'd8, 32'hffff_ffff, 1, ST_OK,      0, 0, 4'd4));
        dir_rows.push_back(mk_row(CMD_NOP_LAST, 4'd8, 32'h0,        1, ST_OK,        0, 0, 4'd4));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd2, 32'h5555_5555, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd2, 32'haaaa_aaaa, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd2, 32'hffff_ffff, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd2, 32'h1,         0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_INS_UN,  4'd8, 32'h3,         1, ST_FULL,      0, 0, 4'd8));
        dir_rows.push_back(mk_row(CMD_INS_ORD, 4'd0, 32'h3,         1, ST_FULL,      0, 0, 4'd8));
        dir_rows.push_back(mk_row(CMD_FIND,    4'd0, 32'hffff_ffff, 0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_FIND,    4'd0, 32'd12345,     1, ST_OK,        0, 0, 4'd8));
        dir_rows.push_back(mk_row(CMD_REM_ORD, 4'd8, 32'h0,         1, ST_BAD_INDEX, 0, 0, 4'd8));
        dir_rows.push_back(mk_row(CMD_REM_UN,  4'd0, 32'h0,         0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_REM_ORD, 4'd6, 32'h0,         0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_REM_UN,  4'd5, 32'h0,         0, ST_OK,        0, 0, 4'd0));
        dir_rows.push_back(mk_row(CMD_NOP_MID, 4'd3, 32'h1,         1, ST_OK,        0, 0, 4'd5));
        dir_rows.push_back(mk_row(CMD_FIND,    4'd0, 32'h7fff_ffff, 0, ST_OK,        0, 0, 4'd0));

        // Reset once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        tick();

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            send_req(row.cmd, row.idx, row.val, row.typed, row.resp, 1'b1);
        end
        drain();

        // Random requests: alternate fill and drain phases so full and empty are hit
        k = 0;
        while (k < N_RANDOM)
        begin
            no_idle = (k >= 200 && k < 300);
            ins_pct = ((k / 40) % 2 == 0) ? 65 : 30;
            if ($urandom_range(99) < 3)
                cmd = CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
            else if ($urandom_range(99) < 20)
                cmd = CMD_FIND;
            else if ($urandom_range(99) < ins_pct)
                cmd = $urandom_range(1) ? CMD_INS_ORD : CMD_INS_UN;
            else
                cmd = $urandom_range(1) ? CMD_REM_ORD : CMD_REM_UN;

            // mostly legal positions, some anywhere from zero up to the depth
            if ($urandom_range(99) < 80 && (cmd == CMD_INS_ORD || cmd == CMD_INS_UN))
                idx = IDX_W'($urandom_range(0, shadow_cnt));
            else if ($urandom_range(99) < 80 && (cmd == CMD_REM_ORD || cmd == CMD_REM_UN)
                     && shadow_cnt > 0)
                idx = IDX_W'($urandom_range(0, shadow_cnt - 1));
            else
                idx = IDX_W'($urandom_range(0, DEPTH));

            if (cmd == CMD_FIND && shadow_cnt > 0 && $urandom_range(1))
                val = shadow_tbl[$urandom_range(0, shadow_cnt - 1)];
            else
                val = pick_value();

            send_req(cmd, idx, val, 1'b0, '0, !no_idle);
            if (cmd <= CMD_FIND)
                k++;
            if (k == 100)
                drain();
        end

        // Wait out the last results
        drain();
        repeat (3) tick();
        if (pending_resp_q.size() != 0)
        begin
            n_errs += pending_resp_q.size();
            $display("ERROR: %0d results never returned", pending_resp_q.size());
        end

        if (n_errs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/iat_pkg.sv
sv/iat_dec.sv
sv/iat_cell.sv
sv/indexed_array_table.sv
tb/sv/tb_top.sv
